// ===== rtl/lfys_pkg.sv =====
// Shared constants and types for the shuffle engine.
package lfys_pkg;

  localparam int MAX_ITEMS     = 64;
  localparam int ELEMENT_WIDTH = 16;
  localparam int ADDR_W        = $clog2(MAX_ITEMS);
  localparam int CNT_W         = $clog2(MAX_ITEMS + 1);
  localparam int DIV_W         = ADDR_W + 1;
  localparam int GEN_W         = 31;
  localparam int STEP_W        = $clog2(GEN_W + 1);

  localparam logic [GEN_W-1:0] LCG_MUL = 31'd1103515245;
  localparam logic [GEN_W-1:0] LCG_ADD = 31'd12345;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEN,
    ST_GEN_WAIT,
    ST_MOD,
    ST_RD_I,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J,
    ST_OUT_RD,
    ST_OUT_LD
  } lfys_state_t;

  typedef struct packed {
    logic             step;
    logic             load;
    logic [GEN_W-1:0] seed;
  } lfys_lcg_ctl_t;

  typedef struct packed {
    logic             start;
    logic [GEN_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } lfys_div_req_t;

endpackage

// ===== rtl/lfys_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module lfys_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lfys_lcg.sv =====
// Linear congruential generator with a registered multiply and a separate add cycle.
module lfys_lcg (
  input  logic                   clk,
  input  logic                   rst,
  input  lfys_pkg::lfys_lcg_ctl_t ctl,
  output logic                   done,
  output logic [lfys_pkg::GEN_W-1:0] value
);
  import lfys_pkg::*;

  logic [GEN_W-1:0] gen_state;
  logic [GEN_W-1:0] prod;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= '0;
      busy      <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.load) begin
        gen_state <= ctl.seed;
        busy      <= 1'b0;
      end else if (busy) begin
        gen_state <= prod + LCG_ADD;
        busy      <= 1'b0;
        done      <= 1'b1;
      end else if (ctl.step) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prod <= GEN_W'(LCG_MUL * gen_state);
    end
  end

  assign value = gen_state;

endmodule

// ===== rtl/lfys_mod.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module lfys_mod (
  input  logic                    clk,
  input  logic                    rst,
  input  lfys_pkg::lfys_div_req_t req,
  output logic                    done,
  output logic [lfys_pkg::ADDR_W-1:0] remainder
);
  import lfys_pkg::*;

  logic [GEN_W-1:0]  dvd;
  logic [DIV_W-1:0]  div;
  logic [DIV_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;

  assign shifted = {rem, dvd[GEN_W-1]};
  assign diff    = shifted - {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd   <= req.dividend;
      div   <= req.divisor;
      rem   <= '0;
      steps <= STEP_W'(GEN_W);
    end else if (busy) begin
      dvd   <= {dvd[GEN_W-2:0], 1'b0};
      steps <= steps - STEP_W'(1);
      if (shifted >= {1'b0, div}) begin
        rem <= diff[DIV_W-1:0];
      end else begin
        rem <= shifted[DIV_W-1:0];
      end
    end
  end

  assign remainder = rem[ADDR_W-1:0];

endmodule

// ===== rtl/lcg_fisher_yates_shuffle_top.sv =====
// Top level of the shuffle engine: load, Fisher-Yates swap sequencer and ordered output.
// Items are accepted only in the idle state and are stalled while a shuffle or output runs.
// Each swap runs the generator, the 31-step serial remainder unit, then reads and writes both RAM entries.
// Output reads the buffer one item at a time and holds each item while out_stall is high.
// Synchronous reset clears the generator, the load count and the output valid flag;
// buffer contents are not cleared.
module lcg_fisher_yates_shuffle_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 seed_we,
  input  logic [lfys_pkg::GEN_W-1:0]           seed,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [lfys_pkg::ELEMENT_WIDTH-1:0]   element,
  input  logic                                 last_element,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lfys_pkg::ELEMENT_WIDTH-1:0]   element_res,
  output logic                                 last_out
);
  import lfys_pkg::*;

  lfys_state_t state, state_next;

  logic [CNT_W-1:0]         cnt;
  logic [ADDR_W-1:0]        idx_i;
  logic [ADDR_W-1:0]        idx_j;
  logic [ADDR_W-1:0]        idx_k;
  logic [ADDR_W-1:0]        last_idx;
  logic [ELEMENT_WIDTH-1:0] hold_i;

  logic                     in_accept;
  logic                     buf_full;
  logic [ADDR_W-1:0]        load_last;
  logic                     out_load;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [ELEMENT_WIDTH-1:0] ram_wdata;
  logic                     ram_re;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [ELEMENT_WIDTH-1:0] ram_rdata;

  lfys_lcg_ctl_t            lcg_ctl;
  logic                     lcg_done;
  logic [GEN_W-1:0]         lcg_value;
  lfys_div_req_t            div_req;
  logic                     mod_done;
  logic [ADDR_W-1:0]        mod_rem;

  assign in_accept = in_valid && !in_stall;
  assign buf_full  = (cnt == CNT_W'(MAX_ITEMS));
  assign load_last = buf_full ? ADDR_W'(MAX_ITEMS - 1) : cnt[ADDR_W-1:0];
  assign out_load  = (state == ST_OUT_LD) && (!out_valid || !out_stall);

  lfys_ram #(
    .WIDTH(ELEMENT_WIDTH),
    .DEPTH(MAX_ITEMS)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lfys_lcg u_lcg (
    .clk  (clk),
    .rst  (rst),
    .ctl  (lcg_ctl),
    .done (lcg_done),
    .value(lcg_value)
  );

  lfys_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && last_element) begin
          state_next = (load_last == '0) ? ST_OUT_RD : ST_GEN;
        end
      end
      ST_GEN:      state_next = ST_GEN_WAIT;
      ST_GEN_WAIT: if (lcg_done) state_next = ST_MOD;
      ST_MOD:      if (mod_done) state_next = ST_RD_I;
      ST_RD_I:     state_next = ST_RD_J;
      ST_RD_J:     state_next = ST_WR_I;
      ST_WR_I:     state_next = ST_WR_J;
      ST_WR_J:     state_next = (idx_i == ADDR_W'(1)) ? ST_OUT_RD : ST_GEN;
      ST_OUT_RD:   state_next = ST_OUT_LD;
      ST_OUT_LD: begin
        if (out_load) begin
          state_next = (idx_k == last_idx) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall         = 1'b1;
    ram_we           = 1'b0;
    ram_waddr        = cnt[ADDR_W-1:0];
    ram_wdata        = element;
    ram_re           = 1'b0;
    ram_raddr        = idx_i;
    lcg_ctl.step     = 1'b0;
    lcg_ctl.load     = seed_we;
    lcg_ctl.seed     = seed;
    div_req.start    = 1'b0;
    div_req.dividend = lcg_value;
    div_req.divisor  = DIV_W'({1'b0, idx_i} + DIV_W'(1));
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        ram_we   = in_valid && !buf_full;
      end
      ST_GEN: begin
        lcg_ctl.step = 1'b1;
      end
      ST_GEN_WAIT: begin
        div_req.start = lcg_done;
      end
      ST_RD_I: begin
        ram_re = 1'b1;
      end
      ST_RD_J: begin
        ram_re    = 1'b1;
        ram_raddr = idx_j;
      end
      ST_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = idx_i;
        ram_wdata = ram_rdata;
      end
      ST_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = idx_j;
        ram_wdata = hold_i;
      end
      ST_OUT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_k;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_accept) begin
        if (last_element) begin
          cnt <= '0;
        end else if (!buf_full) begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept && last_element) begin
      idx_i    <= load_last;
      last_idx <= load_last;
      idx_k    <= '0;
    end
    if (state == ST_MOD && mod_done) begin
      idx_j <= mod_rem;
    end
    if (state == ST_RD_J) begin
      hold_i <= ram_rdata;
    end
    if (state == ST_WR_J) begin
      idx_i <= idx_i - ADDR_W'(1);
    end
    if (out_load) begin
      element_res <= ram_rdata;
      last_out    <= (idx_k == last_idx);
      idx_k       <= idx_k + ADDR_W'(1);
    end
  end

endmodule

// ===== rtl/lfys_checker.sv =====
// Port-level checker for the shuffle engine and its bind to the top level.
module lfys_port_checks (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               last_element,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [lfys_pkg::ELEMENT_WIDTH-1:0] element_res,
  input logic                               last_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(element_res) && $stable(last_out))
    else $error("Stalled output item changed.");

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_element |=> in_stall)
    else $error("Input not stalled after the final element.");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Block not idle after reset.");

endmodule

bind lcg_fisher_yates_shuffle_top lfys_port_checks u_lfys_port_checks (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .last_element(last_element),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .element_res (element_res),
  .last_out    (last_out)
);
